// ===== hdl/adsr_pkg.sv =====
// shared constants, phase and action codes and ramp unit handshake types
// for the adsr envelope generator; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

  localparam int LEVEL_BITS    = 16;
  localparam int TIME_BITS     = 16;
  localparam int FRAC_BITS     = 16;
  localparam int ACC_BITS      = LEVEL_BITS + FRAC_BITS;
  localparam int PROD_BITS     = LEVEL_BITS + TIME_BITS;
  localparam int DIV_BITS      = TIME_BITS + ACC_BITS;
  localparam int MAX_STEPS     = (ACC_BITS > TIME_BITS) ? ACC_BITS : TIME_BITS;
  localparam int CNT_BITS      = $clog2(MAX_STEPS);
  localparam int PHASE_BITS    = 3;
  localparam int ACT_BITS      = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [PHASE_BITS-1:0] PH_INACTIVE = 3'd0;
  localparam logic [PHASE_BITS-1:0] PH_ATTACK   = 3'd1;
  localparam logic [PHASE_BITS-1:0] PH_DECAY    = 3'd2;
  localparam logic [PHASE_BITS-1:0] PH_SUSTAIN  = 3'd3;
  localparam logic [PHASE_BITS-1:0] PH_RELEASE  = 3'd4;

  localparam logic [ACT_BITS-1:0] ACT_TICK = 2'd0;
  localparam logic [ACT_BITS-1:0] ACT_ON   = 2'd1;
  localparam logic [ACT_BITS-1:0] ACT_OFF  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_PEAK    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUSTAIN = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUS_EN  = 3'd5;

  typedef struct packed {
    logic                  start;
    logic [LEVEL_BITS-1:0] span;
    logic [TIME_BITS-1:0]  dt;
    logic [TIME_BITS-1:0]  dur;
  } ramp_req_t;

  typedef struct packed {
    logic                done;
    logic [ACC_BITS-1:0] step;
  } ramp_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/adsr_if.sv =====
// valid/ready channel interfaces for the input, result and configuration
// ports of the adsr envelope generator; depends on adsr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface adsr_in_if import adsr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ACT_BITS-1:0]  action;
  logic [TIME_BITS-1:0] elapsed;

  modport source (output valid, output action, output elapsed, input ready);
  modport sink   (input valid, input action, input elapsed, output ready);
endinterface

interface adsr_out_if import adsr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] amplitude;
  logic [PHASE_BITS-1:0] phase;

  modport source (output valid, output amplitude, output phase, input ready);
  modport sink   (input valid, input amplitude, input phase, output ready);
endinterface

interface adsr_cfg_if import adsr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/adsr_ramp_unit.sv =====
// serial ramp step unit: step = (span * dt << FRAC_BITS) / dur, saturated
// shift-add multiply one bit per cycle, then restoring divide; uses adsr_pkg
`timescale 1ns / 1ps
`default_nettype none

module adsr_ramp_unit import adsr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ramp_req_t req,
  output ramp_rsp_t      rsp
);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_CHK  = 2'd2;
  localparam logic [1:0] U_DIV  = 2'd3;

  logic [1:0]            ust_r, ust_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic                  sat_r, sat_nxt;
  logic [LEVEL_BITS-1:0] span_r, span_nxt;
  logic [TIME_BITS-1:0]  dur_r, dur_nxt;
  logic [PROD_BITS:0]    mul_r, mul_nxt;
  logic [DIV_BITS-1:0]   div_r, div_nxt;

  logic [LEVEL_BITS:0]   mul_sum;
  logic [PROD_BITS-1:0]  prod;
  logic [TIME_BITS:0]    trial;
  logic                  trial_ge;
  logic [TIME_BITS:0]    trial_diff;
  logic [TIME_BITS-1:0]  rem;

  // one multiplier bit per cycle, lsb first
  assign mul_sum = mul_r[PROD_BITS:TIME_BITS]
                 + (mul_r[0] ? {1'b0, span_r} : {(LEVEL_BITS+1){1'b0}});
  assign prod    = mul_r[PROD_BITS-1:0];

  // one quotient bit per cycle, msb first
  assign trial      = div_r[DIV_BITS-1:ACC_BITS-1];
  assign trial_ge   = trial >= {1'b0, dur_r};
  assign trial_diff = trial - {1'b0, dur_r};
  assign rem        = trial_ge ? trial_diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];

  always_comb begin
    ust_nxt  = ust_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    sat_nxt  = sat_r;
    span_nxt = span_r;
    dur_nxt  = dur_r;
    mul_nxt  = mul_r;
    div_nxt  = div_r;
    case (ust_r)
      U_IDLE: begin
        if (req.start) begin
          span_nxt = req.span;
          dur_nxt  = req.dur;
          mul_nxt  = {{(LEVEL_BITS+1){1'b0}}, req.dt};
          sat_nxt  = 1'b0;
          cnt_nxt  = CNT_BITS'(TIME_BITS - 1);
          ust_nxt  = U_MUL;
        end
      end
      U_MUL: begin
        mul_nxt = {1'b0, mul_sum, mul_r[TIME_BITS-1:1]};
        if (cnt_r == '0) begin
          ust_nxt = U_CHK;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      U_CHK: begin
        // quotient overflows the accumulator exactly when prod >= dur << LEVEL_BITS
        div_nxt = {prod, {FRAC_BITS{1'b0}}};
        cnt_nxt = CNT_BITS'(ACC_BITS - 1);
        if (prod[PROD_BITS-1:LEVEL_BITS] >= dur_r) begin
          sat_nxt  = 1'b1;
          done_nxt = 1'b1;
          ust_nxt  = U_IDLE;
        end else begin
          ust_nxt = U_DIV;
        end
      end
      U_DIV: begin
        div_nxt = {rem, div_r[ACC_BITS-2:0], trial_ge};
        if (cnt_r == '0) begin
          done_nxt = 1'b1;
          ust_nxt  = U_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: ust_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ust_r  <= U_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
    end else begin
      ust_r  <= ust_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
      sat_r  <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    span_r <= span_nxt;
    dur_r  <= dur_nxt;
    mul_r  <= mul_nxt;
    div_r  <= div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.step = sat_r ? {ACC_BITS{1'b1}} : div_r[ACC_BITS-1:0];

endmodule

`default_nettype wire

// ===== hdl/adsr_envelope_generator.sv =====
// top level of the linear adsr envelope generator: config registers, phase
// control and result register; uses adsr_pkg, adsr_if and adsr_ramp_unit
`timescale 1ns / 1ps
`default_nettype none

// Linear ADSR envelope with a Q16.16 accumulator. Each input item is a tick
// carrying elapsed time, a gate-on or a gate-off, and each one returns exactly
// one result item holding the integer part of the level and the phase after
// the update. Gate actions, ticks in inactive or sustain, ticks with a zero
// phase time and unknown actions pass only through the done state, which
// waits for a free result register, before the next item can be accepted.
// A ramping tick runs through the serial step unit, a one-bit-per-cycle
// multiply followed by a saturation check and a restoring divide; a step
// that saturates skips the divide. The result sits in an output register, so
// the next item is accepted while it waits. Configuration writes are ready
// only while the block is idle and take effect at the accepting edge.
module adsr_envelope_generator import adsr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  adsr_in_if.sink    in_chan,
  adsr_out_if.source out_chan,
  adsr_cfg_if.sink   cfg_chan
);

  // control states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            st_r, st_nxt;
  logic [ACC_BITS-1:0]   acc_r, acc_nxt;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic                  gate_r, gate_nxt;

  // configuration registers
  logic [LEVEL_BITS-1:0] peak_r, peak_nxt;
  logic [LEVEL_BITS-1:0] sus_r, sus_nxt;
  logic [TIME_BITS-1:0]  att_dur_r, att_dur_nxt;
  logic [TIME_BITS-1:0]  dec_dur_r, dec_dur_nxt;
  logic [TIME_BITS-1:0]  rel_dur_r, rel_dur_nxt;
  logic                  sus_en_r, sus_en_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [LEVEL_BITS-1:0] out_amp_r, out_amp_nxt;
  logic [PHASE_BITS-1:0] out_phase_r, out_phase_nxt;

  ramp_req_t             ramp_req;
  ramp_rsp_t             ramp_rsp;

  logic                  in_fire;
  logic                  out_free;
  logic [LEVEL_BITS-1:0] span_dec;
  logic [LEVEL_BITS-1:0] sel_span;
  logic [TIME_BITS-1:0]  sel_dur;
  logic                  dur_zero;
  logic                  ramp_phase;
  logic [ACC_BITS-1:0]   peak_f;
  logic [ACC_BITS-1:0]   sus_f;
  logic [ACC_BITS:0]     acc_sum;
  logic [ACC_BITS-1:0]   acc_down;
  logic [ACC_BITS-1:0]   upd_acc;
  logic [PHASE_BITS-1:0] upd_phase;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready   = (st_r == ST_IDLE);
  assign cfg_chan.ready  = (st_r == ST_IDLE);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.amplitude = out_amp_r;
  assign out_chan.phase     = out_phase_r;

  assign peak_f = {peak_r, {FRAC_BITS{1'b0}}};
  assign sus_f  = {sus_r, {FRAC_BITS{1'b0}}};

  // peak below sustain gives a flat decay
  assign span_dec = (peak_r > sus_r) ? (peak_r - sus_r) : {LEVEL_BITS{1'b0}};

  // slope span and phase time for the current phase
  always_comb begin
    case (phase_r)
      PH_ATTACK: begin
        sel_span = peak_r;
        sel_dur  = att_dur_r;
      end
      PH_DECAY: begin
        sel_span = span_dec;
        sel_dur  = dec_dur_r;
      end
      default: begin
        sel_span = sus_r;
        sel_dur  = rel_dur_r;
      end
    endcase
  end

  assign dur_zero   = (sel_dur == '0);
  assign ramp_phase = (phase_r == PH_ATTACK) || (phase_r == PH_DECAY) ||
                      (phase_r == PH_RELEASE);

  assign ramp_req.span = sel_span;
  assign ramp_req.dt   = in_chan.elapsed;
  assign ramp_req.dur  = sel_dur;
  assign ramp_req.start = (st_r == ST_IDLE) && in_fire && (in_chan.action == ACT_TICK) &&
                          ramp_phase && !dur_zero;

  adsr_ramp_unit u_ramp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ramp_req),
    .rsp   (ramp_rsp)
  );

  // up ramp saturates at the accumulator top, down ramps floor at zero
  assign acc_sum  = {1'b0, acc_r} + {1'b0, ramp_rsp.step};
  assign acc_down = (acc_r > ramp_rsp.step) ? (acc_r - ramp_rsp.step) : {ACC_BITS{1'b0}};

  // tick update of level and phase; a zero phase time jumps to the target
  always_comb begin
    upd_acc   = acc_r;
    upd_phase = phase_r;
    case (phase_r)
      PH_ATTACK: begin
        if (dur_zero) begin
          upd_acc = peak_f;
        end else if (acc_sum[ACC_BITS]) begin
          upd_acc = {ACC_BITS{1'b1}};
        end else begin
          upd_acc = acc_sum[ACC_BITS-1:0];
        end
        if (upd_acc >= peak_f) begin
          upd_acc   = peak_f;
          upd_phase = PH_DECAY;
        end
      end
      PH_DECAY: begin
        upd_acc = dur_zero ? sus_f : acc_down;
        if (upd_acc <= sus_f) begin
          upd_acc   = sus_f;
          upd_phase = sus_en_r ? PH_SUSTAIN : PH_RELEASE;
        end
      end
      PH_SUSTAIN: begin
        if (!gate_r) begin
          upd_phase = PH_RELEASE;
        end
      end
      PH_RELEASE: begin
        upd_acc = dur_zero ? {ACC_BITS{1'b0}} : acc_down;
        if (upd_acc == '0) begin
          upd_phase = PH_INACTIVE;
        end
      end
      default: begin
        upd_acc   = acc_r;
        upd_phase = phase_r;
      end
    endcase
  end

  // item control
  always_comb begin
    st_nxt        = st_r;
    acc_nxt       = acc_r;
    phase_nxt     = phase_r;
    gate_nxt      = gate_r;
    out_valid_nxt = out_valid_r;
    out_amp_nxt   = out_amp_r;
    out_phase_nxt = out_phase_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          st_nxt = ST_DONE;
          case (in_chan.action)
            ACT_ON: begin
              gate_nxt  = 1'b1;
              phase_nxt = PH_ATTACK;
            end
            ACT_OFF: begin
              gate_nxt  = 1'b0;
              phase_nxt = PH_RELEASE;
            end
            ACT_TICK: begin
              if (ramp_phase && !dur_zero) begin
                st_nxt = ST_CALC;
              end else begin
                acc_nxt   = upd_acc;
                phase_nxt = upd_phase;
              end
            end
            default: begin
              // unknown action: report the current state unchanged
              st_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_CALC: begin
        if (ramp_rsp.done) begin
          acc_nxt   = upd_acc;
          phase_nxt = upd_phase;
          st_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_amp_nxt   = acc_r[ACC_BITS-1:FRAC_BITS];
          out_phase_nxt = phase_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // configuration writes, indexes past the list are dropped
  always_comb begin
    peak_nxt    = peak_r;
    sus_nxt     = sus_r;
    att_dur_nxt = att_dur_r;
    dec_dur_nxt = dec_dur_r;
    rel_dur_nxt = rel_dur_r;
    sus_en_nxt  = sus_en_r;
    if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.index)
        REG_PEAK:    peak_nxt    = cfg_chan.data[LEVEL_BITS-1:0];
        REG_SUSTAIN: sus_nxt     = cfg_chan.data[LEVEL_BITS-1:0];
        REG_ATTACK:  att_dur_nxt = cfg_chan.data[TIME_BITS-1:0];
        REG_DECAY:   dec_dur_nxt = cfg_chan.data[TIME_BITS-1:0];
        REG_RELEASE: rel_dur_nxt = cfg_chan.data[TIME_BITS-1:0];
        REG_SUS_EN:  sus_en_nxt  = cfg_chan.data[0];
        default:     sus_en_nxt  = sus_en_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      acc_r       <= '0;
      phase_r     <= PH_INACTIVE;
      gate_r      <= 1'b0;
      peak_r      <= '0;
      sus_r       <= '0;
      att_dur_r   <= '0;
      dec_dur_r   <= '0;
      rel_dur_r   <= '0;
      sus_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      acc_r       <= acc_nxt;
      phase_r     <= phase_nxt;
      gate_r      <= gate_nxt;
      peak_r      <= peak_nxt;
      sus_r       <= sus_nxt;
      att_dur_r   <= att_dur_nxt;
      dec_dur_r   <= dec_dur_nxt;
      rel_dur_r   <= rel_dur_nxt;
      sus_en_r    <= sus_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_amp_r   <= out_amp_nxt;
    out_phase_r <= out_phase_nxt;
  end

endmodule

`default_nettype wire
